// ===== src/clb_pkg.sv =====
// clb_pkg: shared constants, field widths and result codes for the cell bucket core
// no dependencies
`timescale 1ns / 1ps

package clb_pkg;

	localparam int NUM_CELLS_DEF      = 1024;
	localparam int SLOTS_PER_CELL_DEF = 16;
	localparam int ID_BITS_DEF        = 16;

	localparam int OPCODE_W     = 1;
	localparam int CELL_INDEX_W = 10;
	localparam int PID_W        = 16;
	localparam int STATUS_W     = 2;
	localparam int CNT_OUT_W    = 5;
	localparam int SLOT_OUT_W   = 4;

	localparam logic [OPCODE_W-1:0] OP_INSERT = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_DELETE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NOMATCH = 2'd2
	} status_t;

endpackage

// ===== src/clb_ram.sv =====
// clb_ram: simple dual-port synchronous ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module clb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/clb_seq.sv =====
// clb_seq: sequencer for insert and delete, drives the count and slot memories
// depends on clb_pkg; memories live in clb_ram instances at the top level
`timescale 1ns / 1ps

module clb_seq
	import clb_pkg::*;
#(
	parameter int NUM_CELLS      = NUM_CELLS_DEF,
	parameter int SLOTS_PER_CELL = SLOTS_PER_CELL_DEF,
	parameter int ID_BITS        = ID_BITS_DEF,
	localparam int CELL_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1,
	localparam int CNT_W      = $clog2(SLOTS_PER_CELL + 1),
	localparam int SLOT_W     = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1,
	localparam int DEPTH      = NUM_CELLS * SLOTS_PER_CELL,
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CELL_REG_W = (CELL_W > CELL_INDEX_W) ? CELL_W : CELL_INDEX_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [OPCODE_W-1:0]     opcode,
	input  logic [CELL_INDEX_W-1:0] cell_index,
	input  logic [PID_W-1:0]        particle_id,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [STATUS_W-1:0]     status,
	output logic [CNT_OUT_W-1:0]    cell_count,
	output logic [SLOT_OUT_W-1:0]   slot_used,
	output logic                    cnt_we,
	output logic [CELL_W-1:0]       cnt_waddr,
	output logic [CNT_W-1:0]        cnt_wdata,
	output logic                    cnt_re,
	output logic [CELL_W-1:0]       cnt_raddr,
	input  logic [CNT_W-1:0]        cnt_rdata,
	output logic                    slot_we,
	output logic [ADDR_W-1:0]       slot_waddr,
	output logic [ID_BITS-1:0]      slot_wdata,
	output logic                    slot_re,
	output logic [ADDR_W-1:0]       slot_raddr,
	input  logic [ID_BITS-1:0]      slot_rdata
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_REDUCE,
		S_COUNT,
		S_SCAN,
		S_MOVE,
		S_RESULT
	} state_t;

	state_t                state_q;
	logic [CELL_W-1:0]     clr_q;
	logic [OPCODE_W-1:0]   op_q;
	logic [CELL_REG_W-1:0] cell_q;
	logic [ID_BITS-1:0]    id_q;
	logic [ADDR_W-1:0]     base_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic                  cmp_v_s1;
	logic [CNT_W-1:0]      cmp_idx_s1;
	logic [SLOT_W-1:0]     hit_idx_q;
	status_t               res_status_q;
	logic [CNT_W-1:0]      res_cnt_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic                  rsp_valid_q;
	status_t               status_q;
	logic [CNT_W-1:0]      count_q;
	logic [SLOT_W-1:0]     slot_q;

	logic [CNT_W-1:0]      cnt_in;
	logic                  cell_over;
	logic                  hit;
	logic                  last_s1;
	logic [CELL_W-1:0]     cell_addr;

	assign cnt_in    = (cnt_rdata > CNT_W'(SLOTS_PER_CELL)) ? CNT_W'(SLOTS_PER_CELL) : cnt_rdata;
	assign cell_over = 32'(cell_q) >= 32'(NUM_CELLS);
	assign hit       = cmp_v_s1 && (slot_rdata == id_q);
	assign last_s1   = cmp_idx_s1 == (cnt_q - CNT_W'(1));
	assign cell_addr = cell_q[CELL_W-1:0];

	assign req_stall  = (state_q != S_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign cell_count = CNT_OUT_W'(count_q);
	assign slot_used  = SLOT_OUT_W'(slot_q);

	// memory port control
	always_comb begin
		cnt_we     = 1'b0;
		cnt_waddr  = cell_addr;
		cnt_wdata  = '0;
		cnt_re     = 1'b0;
		cnt_raddr  = cell_addr;
		slot_we    = 1'b0;
		slot_waddr = base_q;
		slot_wdata = id_q;
		slot_re    = 1'b0;
		slot_raddr = base_q;
		case (state_q)
			S_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
			end
			S_REDUCE: begin
				cnt_re = !cell_over;
			end
			S_COUNT: begin
				if (op_q == OP_INSERT) begin
					if (cnt_in < CNT_W'(SLOTS_PER_CELL)) begin
						slot_we    = 1'b1;
						slot_waddr = base_q + ADDR_W'(cnt_in);
						cnt_we     = 1'b1;
						cnt_wdata  = cnt_in + CNT_W'(1);
					end
				end else if (cnt_in != '0) begin
					slot_re = 1'b1;
				end
			end
			S_SCAN: begin
				if (hit) begin
					slot_re    = 1'b1;
					slot_raddr = base_q + ADDR_W'(cnt_q - CNT_W'(1));
				end else if (rd_idx_q < cnt_q) begin
					slot_re    = 1'b1;
					slot_raddr = base_q + ADDR_W'(rd_idx_q);
				end
			end
			S_MOVE: begin
				// last entry fills the freed slot
				slot_we    = 1'b1;
				slot_waddr = base_q + ADDR_W'(hit_idx_q);
				slot_wdata = slot_rdata;
				cnt_we     = 1'b1;
				cnt_wdata  = cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			op_q         <= OP_INSERT;
			cell_q       <= '0;
			id_q         <= '0;
			base_q       <= '0;
			cnt_q        <= '0;
			rd_idx_q     <= '0;
			cmp_v_s1     <= 1'b0;
			cmp_idx_s1   <= '0;
			hit_idx_q    <= '0;
			res_status_q <= ST_OK;
			res_cnt_q    <= '0;
			res_slot_q   <= '0;
			rsp_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			count_q      <= '0;
			slot_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_RESULT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CELL_W'(1);
					if (clr_q == CELL_W'(NUM_CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= opcode;
						cell_q  <= CELL_REG_W'(cell_index);
						id_q    <= ID_BITS'(particle_id);
						state_q <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (cell_over) begin
						cell_q <= cell_q - CELL_REG_W'(NUM_CELLS);
					end else begin
						base_q  <= ADDR_W'(cell_addr * SLOTS_PER_CELL);
						state_q <= S_COUNT;
					end
				end
				S_COUNT: begin
					cnt_q <= cnt_in;
					if (op_q == OP_INSERT) begin
						if (cnt_in < CNT_W'(SLOTS_PER_CELL)) begin
							res_status_q <= ST_OK;
							res_cnt_q    <= cnt_in + CNT_W'(1);
							res_slot_q   <= SLOT_W'(cnt_in);
						end else begin
							res_status_q <= ST_FULL;
							res_cnt_q    <= cnt_in;
							res_slot_q   <= '0;
						end
						state_q <= S_RESULT;
					end else if (cnt_in == '0) begin
						res_status_q <= ST_NOMATCH;
						res_cnt_q    <= cnt_in;
						res_slot_q   <= '0;
						state_q      <= S_RESULT;
					end else begin
						rd_idx_q   <= CNT_W'(1);
						cmp_v_s1   <= 1'b1;
						cmp_idx_s1 <= '0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						hit_idx_q <= SLOT_W'(cmp_idx_s1);
						cmp_v_s1  <= 1'b0;
						state_q   <= S_MOVE;
					end else if (cmp_v_s1 && last_s1) begin
						res_status_q <= ST_NOMATCH;
						res_cnt_q    <= cnt_q;
						res_slot_q   <= '0;
						cmp_v_s1     <= 1'b0;
						state_q      <= S_RESULT;
					end else begin
						cmp_v_s1   <= rd_idx_q < cnt_q;
						cmp_idx_s1 <= rd_idx_q;
						if (rd_idx_q < cnt_q) begin
							rd_idx_q <= rd_idx_q + CNT_W'(1);
						end
					end
				end
				S_MOVE: begin
					res_status_q <= ST_OK;
					res_cnt_q    <= cnt_q - CNT_W'(1);
					res_slot_q   <= hit_idx_q;
					state_q      <= S_RESULT;
				end
				S_RESULT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						status_q    <= res_status_q;
						count_q     <= res_cnt_q;
						slot_q      <= res_slot_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// one item in flight at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("item accepted while another is in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(slot_we && slot_re))
		else $error("slot memory read and written in one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (cnt_wdata <= CNT_W'(SLOTS_PER_CELL)))
		else $error("bucket count written beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q != ST_OK) |-> (slot_q == '0))
		else $error("slot reported on a refused operation");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOVE) |-> $past(hit))
		else $error("swap without a matching entry");

endmodule

// ===== src/cell_bucket_insert_delete_core.sv =====
// cell_bucket_insert_delete_core: spatial cell-list table with bounded buckets
// depends on clb_pkg, clb_ram, clb_seq
//
//  channel | handshake            | word
//  req     | req_valid, req_stall | opcode, cell_index, particle_id
//  rsp     | rsp_valid, rsp_stall | status, cell_count, slot_used
//
// insert, or delete on an empty cell: S_REDUCE, S_COUNT, S_RESULT, then the result register
// other delete: S_SCAN to a match or the last slot, S_MOVE on a match, then S_RESULT;
//   the scan reads one slot a cycle through the slot memory read port
// after reset the count memory is cleared one cell a cycle, all NUM_CELLS cells,
//   and req_stall stays high meanwhile
// a held result in the output register does not block the next accept
`timescale 1ns / 1ps

module cell_bucket_insert_delete_core
	import clb_pkg::*;
#(
	parameter int NUM_CELLS      = NUM_CELLS_DEF,
	parameter int SLOTS_PER_CELL = SLOTS_PER_CELL_DEF,
	parameter int ID_BITS        = ID_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [OPCODE_W-1:0]     opcode,
	input  logic [CELL_INDEX_W-1:0] cell_index,
	input  logic [PID_W-1:0]        particle_id,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [STATUS_W-1:0]     status,
	output logic [CNT_OUT_W-1:0]    cell_count,
	output logic [SLOT_OUT_W-1:0]   slot_used
);

	localparam int CELL_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int CNT_W  = $clog2(SLOTS_PER_CELL + 1);
	localparam int DEPTH  = NUM_CELLS * SLOTS_PER_CELL;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic               cnt_we;
	logic [CELL_W-1:0]  cnt_waddr;
	logic [CNT_W-1:0]   cnt_wdata;
	logic               cnt_re;
	logic [CELL_W-1:0]  cnt_raddr;
	logic [CNT_W-1:0]   cnt_rdata;
	logic               slot_we;
	logic [ADDR_W-1:0]  slot_waddr;
	logic [ID_BITS-1:0] slot_wdata;
	logic               slot_re;
	logic [ADDR_W-1:0]  slot_raddr;
	logic [ID_BITS-1:0] slot_rdata;

	clb_seq #(
		.NUM_CELLS      (NUM_CELLS),
		.SLOTS_PER_CELL (SLOTS_PER_CELL),
		.ID_BITS        (ID_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.opcode      (opcode),
		.cell_index  (cell_index),
		.particle_id (particle_id),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.cell_count  (cell_count),
		.slot_used   (slot_used),
		.cnt_we      (cnt_we),
		.cnt_waddr   (cnt_waddr),
		.cnt_wdata   (cnt_wdata),
		.cnt_re      (cnt_re),
		.cnt_raddr   (cnt_raddr),
		.cnt_rdata   (cnt_rdata),
		.slot_we     (slot_we),
		.slot_waddr  (slot_waddr),
		.slot_wdata  (slot_wdata),
		.slot_re     (slot_re),
		.slot_raddr  (slot_raddr),
		.slot_rdata  (slot_rdata)
	);

	// per-cell fill counts
	clb_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_CELLS)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	// bucket slots, cell-major
	clb_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

endmodule

// ===== tb/cell_bucket_insert_delete_core_tb.sv =====
// cell_bucket_insert_delete_core_tb: self-checking bench for the cell bucket core,
// with bursty request traffic, patterned response stalls and a scoreboard fed by a bucket predictor
// depends on clb_pkg and cell_bucket_insert_delete_core
`timescale 1ns / 1ps

module cell_bucket_insert_delete_core_tb;
	import clb_pkg::*;

	localparam int CELLS = NUM_CELLS_DEF;
	localparam int SLOTS = SLOTS_PER_CELL_DEF;

	typedef struct {
		logic [OPCODE_W-1:0]     op;
		logic [CELL_INDEX_W-1:0] cell_idx;
		logic [PID_W-1:0]        pid;
	} req_word_t;

	typedef struct {
		status_t                 st;
		logic [CNT_OUT_W-1:0]    cnt;
		logic [SLOT_OUT_W-1:0]   slot;
	} bucket_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_stall;
	logic [OPCODE_W-1:0]     opcode = OP_INSERT;
	logic [CELL_INDEX_W-1:0] cell_index = '0;
	logic [PID_W-1:0]        particle_id = '0;
	logic                    rsp_valid;
	logic                    rsp_stall = 1'b0;
	logic [STATUS_W-1:0]     status;
	logic [CNT_OUT_W-1:0]    cell_count;
	logic [SLOT_OUT_W-1:0]   slot_used;

	req_word_t      pending_words[$];
	bucket_result_t expected_results[$];

	logic [CNT_OUT_W-1:0] bucket_fill [CELLS];
	logic [PID_W-1:0]     bucket_ids [CELLS][SLOTS];

	int error_count = 0;
	int accepted_words = 0;
	int checked_results = 0;
	int ok_results = 0;
	int full_results = 0;
	int nomatch_results = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int mode_left = 0;

	cell_bucket_insert_delete_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.opcode      (opcode),
		.cell_index  (cell_index),
		.particle_id (particle_id),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.cell_count  (cell_count),
		.slot_used   (slot_used)
	);

	always #5 clk = ~clk;

	initial begin
		for (int c = 0; c < CELLS; c++)
			bucket_fill[c] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic bucket_result_t apply_bucket_op(req_word_t w);
		bucket_result_t r;
		int n;
		int hit;
		n = int'(bucket_fill[w.cell_idx]);
		hit = -1;
		r.st = ST_OK;
		r.slot = '0;
		if (w.op == OP_INSERT) begin
			if (n >= SLOTS) begin
				r.st = ST_FULL;
			end else begin
				bucket_ids[w.cell_idx][n] = w.pid;
				r.slot = SLOT_OUT_W'(n);
				n++;
			end
		end else begin
			for (int i = 0; i < n; i++)
				if (hit < 0 && bucket_ids[w.cell_idx][i] == w.pid)
					hit = i;
			if (hit < 0) begin
				r.st = ST_NOMATCH;
			end else begin
				// last entry fills the freed slot
				bucket_ids[w.cell_idx][hit] = bucket_ids[w.cell_idx][n-1];
				n--;
				r.slot = SLOT_OUT_W'(hit);
			end
		end
		bucket_fill[w.cell_idx] = CNT_OUT_W'(n);
		r.cnt = CNT_OUT_W'(n);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at result %0d: %s got %0d expected %0d",
			checked_results, what, got, want);
		error_count++;
	endtask

	function automatic void add_word(logic [OPCODE_W-1:0] op, int cell_idx, int pid);
		req_word_t w;
		w.op = op;
		w.cell_idx = CELL_INDEX_W'(cell_idx);
		w.pid = PID_W'(pid);
		pending_words.push_back(w);
	endfunction

	// request driver: bursts of words separated by random gaps
	always @(posedge clk or negedge arst_n) begin : drive_proc
		req_word_t nxt;
		req_word_t held;
		if (!arst_n) begin
			req_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				held.op = opcode;
				held.cell_idx = cell_index;
				held.pid = particle_id;
				expected_results.push_back(apply_bucket_op(held));
				accepted_words++;
			end
			if (!(req_valid && req_stall)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					nxt = pending_words.pop_front();
					opcode <= nxt.op;
					cell_index <= nxt.cell_idx;
					particle_id <= nxt.pid;
					req_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(24, 1);
						gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(9, 1);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and stall pattern
	always @(posedge clk or negedge arst_n) begin : watch_proc
		bucket_result_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("word with nothing pending, status", int'(status), -1);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.st)
						report_mismatch("status", int'(status), int'(want.st));
					if (cell_count !== want.cnt)
						report_mismatch("cell_count", int'(cell_count), int'(want.cnt));
					if (slot_used !== want.slot)
						report_mismatch("slot_used", int'(slot_used), int'(want.slot));
					case (want.st)
						ST_OK:   ok_results++;
						ST_FULL: full_results++;
						default: nomatch_results++;
					endcase
				end
				checked_results++;
			end
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(3, 0);
				mode_left <= $urandom_range(80, 8);
				rsp_stall <= 1'b0;
			end else begin
				mode_left <= mode_left - 1;
				case (stall_mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(3, 0) == 0);
					2: rsp_stall <= ($urandom_range(9, 0) < 7);
					default: rsp_stall <= 1'b1;
				endcase
			end
		end
	end

	initial begin : stim_proc
		logic [CELL_INDEX_W-1:0] hot_cells [6];
		logic [PID_W-1:0]        id_pool [10];
		int insert_pct;
		req_word_t w;

		// duplicates, delete at slot zero, no match, empty cell, top cell index
		add_word(OP_INSERT, 1023, 16'hFFFF);
		add_word(OP_INSERT, 1023, 16'h0000);
		add_word(OP_INSERT, 1023, 16'hFFFF);
		add_word(OP_DELETE, 1023, 16'hFFFF);
		add_word(OP_DELETE, 1023, 16'h1234);
		add_word(OP_DELETE, 5, 16'h0000);
		// fill cell zero, then refuse one more insert
		for (int i = 0; i < SLOTS; i++)
			add_word(OP_INSERT, 0, 16'h0100 + i);
		add_word(OP_INSERT, 0, 16'hBEEF);
		add_word(OP_DELETE, 0, 16'h0107);
		add_word(OP_DELETE, 0, 16'h010F);

		for (int k = 0; k < 6; k++)
			hot_cells[k] = CELL_INDEX_W'($urandom_range(1023, 0));
		for (int k = 0; k < 10; k++)
			id_pool[k] = PID_W'($urandom_range(65535, 0));
		insert_pct = 85;
		for (int n = 0; n < 1525; n++) begin
			if (n % 100 == 0 && n >= 200)
				case ($urandom_range(2, 0))
					0: insert_pct = 85;
					1: insert_pct = 50;
					default: insert_pct = 20;
				endcase
			w.op = ($urandom_range(99, 0) < insert_pct) ? OP_INSERT : OP_DELETE;
			if ($urandom_range(99, 0) < 85)
				w.cell_idx = hot_cells[$urandom_range(5, 0)];
			else
				w.cell_idx = CELL_INDEX_W'($urandom_range(1023, 0));
			if ($urandom_range(99, 0) < 75)
				w.pid = id_pool[$urandom_range(9, 0)];
			else
				w.pid = PID_W'($urandom_range(65535, 0));
			pending_words.push_back(w);
		end

		@(posedge arst_n);
		while (pending_words.size() != 0 || req_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("words still pending at end", expected_results.size(), 0);

		$display("run covered %0d request words and %0d results", accepted_words,
			checked_results);
		$display("results: %0d ok, %0d bucket full, %0d no match", ok_results,
			full_results, nomatch_results);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
src/clb_pkg.sv
src/clb_ram.sv
src/clb_seq.sv
src/cell_bucket_insert_delete_core.sv
tb/cell_bucket_insert_delete_core_tb.sv
